### hdl/kop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kop_pkg;

  localparam int MaxIterationsDefault = 32;
  localparam int AngleFracBitsDefault = 20;

  // fraction part of 2*pi in Q30 above the integer turn (2*pi*2^30 = 2^32 + this)
  localparam logic [31:0] TwoPiFrac = 32'd2451551556;
  localparam logic [33:0] PiHalfQ30 = 34'd1686629713;
  localparam logic [33:0] PiQuarterQ30 = 34'd843314856;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSemiMajor = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEccentricity = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriod = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV,
    ST_MMUL,
    ST_MSET,
    ST_RED0,
    ST_RED,
    ST_SQ,
    ST_X2,
    ST_TM,
    ST_TR,
    ST_TQ,
    ST_TC,
    ST_TFIN,
    ST_IMUL,
    ST_IUPD,
    ST_XMUL,
    ST_XRND,
    ST_SQI,
    ST_SQRT,
    ST_YM1,
    ST_YM2,
    ST_YRND
  } kop_state_e;

  // series term divisor: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  function automatic logic [7:0] term_div(input logic [2:0] k, input logic is_cos);
    logic [7:0] d;
    d = 8'd1;
    case ({is_cos, k})
      4'b0_001: d = 8'd6;
      4'b0_010: d = 8'd20;
      4'b0_011: d = 8'd42;
      4'b0_100: d = 8'd72;
      4'b0_101: d = 8'd110;
      4'b0_110: d = 8'd156;
      4'b0_111: d = 8'd210;
      4'b1_001: d = 8'd2;
      4'b1_010: d = 8'd12;
      4'b1_011: d = 8'd30;
      4'b1_100: d = 8'd56;
      4'b1_101: d = 8'd90;
      4'b1_110: d = 8'd132;
      4'b1_111: d = 8'd182;
      default:  d = 8'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), quotient estimate is low by at most one
  function automatic logic [31:0] term_recip(input logic [2:0] k, input logic is_cos);
    logic [31:0] r;
    r = 32'd0;
    case ({is_cos, k})
      4'b0_001: r = 32'd715827882;
      4'b0_010: r = 32'd214748364;
      4'b0_011: r = 32'd102261126;
      4'b0_100: r = 32'd59652323;
      4'b0_101: r = 32'd39045157;
      4'b0_110: r = 32'd27531841;
      4'b0_111: r = 32'd20452225;
      4'b1_001: r = 32'd2147483648;
      4'b1_010: r = 32'd357913941;
      4'b1_011: r = 32'd143165576;
      4'b1_100: r = 32'd76695844;
      4'b1_101: r = 32'd47721858;
      4'b1_110: r = 32'd32537631;
      4'b1_111: r = 32'd23598721;
      default:  r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/kepler_orbit_position.sv
`timescale 1ns / 1ps
`default_nettype none
// Kepler orbit position solver. Each time_req transfer gives one result: the planar
// position (pos_x, pos_y) of a body on an ellipse with semi-major axis a and
// eccentricity e (Q0.16), at time time_req modulo the orbital period, plus a flag
// telling whether Kepler's equation E = M + e*sin(E) met a 1e-5 rad tolerance
// before MAX_ITERATIONS updates. Angles are Q(ANGLE_FRACTION_BITS) radians.
// The block handles one item at a time: in_stall_o is high from the accepted
// transfer until the result is loaded into the output register, which then waits
// for the consumer while the next item can already be taken. Work is done by a
// single shared 32x32 multiplier reused by a small sequencer: the bit-serial
// period divider (skipped for a zero period), the mean anomaly, each
// sine/cosine evaluation (at most 5 range-reduction subtracts, then 7 series
// terms each for sine and cosine), each Kepler update, up to MAX_ITERATIONS of
// them, and the final position including a 31 step square root and the output
// load. Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user is to write them only while idle, which the block itself does not
// enforce; an unknown index is ignored.
module kepler_orbit_position #(
  parameter int MAX_ITERATIONS = kop_pkg::MaxIterationsDefault,
  parameter int ANGLE_FRACTION_BITS = kop_pkg::AngleFracBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [kop_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [31:0]                  cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [31:0]                  time_req_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [25:0]                pos_x_o,
  output logic signed [25:0]                pos_y_o,
  output logic                              converged_o
);
  import kop_pkg::*;

  localparam int AW = ANGLE_FRACTION_BITS + 4;          // signed angle width
  localparam int IW = $clog2(MAX_ITERATIONS + 1);
  localparam int QShift = 30 - ANGLE_FRACTION_BITS;     // angle to Q30
  localparam int StepShift = 46 - ANGLE_FRACTION_BITS;
  localparam logic [63:0] StepRound = 64'd1 << (StepShift - 1);
  localparam longint unsigned TolRaw =
    ((64'd1 << ANGLE_FRACTION_BITS) + 64'd50000) / 64'd100000;
  localparam longint unsigned TolVal = (TolRaw == 0) ? 64'd1 : TolRaw;
  localparam logic [AW:0] Tol = (AW+1)'(TolVal);

  // configuration
  logic [23:0] semi_q;
  logic [15:0] ecc_q;
  logic [31:0] period_q;

  kop_state_e state_q, state_d;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q;

  // divider and square root
  logic [63:0] dq_q;
  logic [31:0] rem_q;
  logic [5:0]  cnt_q;
  logic [60:0] sq_v_q, sq_res_q, sq_bit_q;

  // solver
  logic signed [AW-1:0] m_q, eprev_q, ang_q;
  logic            final_q;
  logic [IW-1:0]   iter_q;
  logic            conv_q;

  // trig
  logic [33:0]     y_q;
  logic [2:0]      quad_q;
  logic            rneg_q;
  logic [29:0]     ra_q, x2_q, n_q, qe_q;
  logic [30:0]     ts_q, tc_q;
  logic signed [31:0] ss_q, cc_q, s30_q, c30_q;
  logic [2:0]      k_q;
  logic            cos_sel_q;
  logic            dneg_q;

  // result
  logic [25:0]     xres_q;
  logic            out_valid_q;
  logic [25:0]     pos_x_q, pos_y_q;
  logic            conv_out_q;

  // combinational helpers
  logic [32:0] r_sh;
  logic        div_ge;
  logic [32:0] m30;
  logic [AW-1:0] ang_mag;
  logic [34:0] r_diff;
  logic [29:0] n_val, qe_val, t_rem, term;
  logic [7:0]  t_div;
  logic signed [31:0] s_base, sn, cn;
  logic [31:0] s_abs;
  logic [AW-1:0] step;
  logic signed [AW-1:0] ecur_d;
  logic signed [AW:0] dlt;
  logic [AW:0] dlt_abs;
  logic        iter_done, iter_last;
  logic signed [31:0] dval;
  logic [31:0] d_mag;
  logic [61:0] sq_sum;
  logic        sq_ge;
  logic        out_free;

  function automatic logic [25:0] round_sat(input logic neg, input logic [63:0] mag);
    logic [63:0] m;
    m = (mag + 64'd536870912) >> 30;
    if (neg) begin
      if (m > 64'd33554432) m = 64'd33554432;
      return 26'(64'd0 - m);
    end
    if (m > 64'd33554431) m = 64'd33554431;
    return 26'(m);
  endfunction

  // datapath helpers
  always_comb begin
    r_sh    = {rem_q, dq_q[63]};
    div_ge  = r_sh >= {1'b0, period_q};
    m30     = {1'b0, dq_q[31:0]} + {1'b0, prod_q[63:32]};
    ang_mag = ang_q[AW-1] ? AW'(-ang_q) : AW'(ang_q);
    r_diff  = {1'b0, y_q} - {1'b0, PiQuarterQ30};
    n_val   = 30'(prod_q >> 30);
    qe_val  = 30'(prod_q >> 32);
    t_div   = term_div(k_q, cos_sel_q);
    t_rem   = n_q - prod_q[29:0];
    term    = (t_rem >= {22'd0, t_div}) ? qe_q + 30'd1 : qe_q;
    s_base  = rneg_q ? -ss_q : ss_q;
    case (quad_q[1:0])
      2'd0:    begin sn = s_base; cn = cc_q;    end
      2'd1:    begin sn = cc_q;   cn = -s_base; end
      2'd2:    begin sn = -s_base; cn = -cc_q;  end
      default: begin sn = -cc_q;  cn = s_base;  end
    endcase
    s_abs   = s30_q[31] ? 32'(-s30_q) : 32'(s30_q);
    step    = AW'((prod_q + StepRound) >> StepShift);
    ecur_d  = s30_q[31] ? m_q - $signed(step) : m_q + $signed(step);
    dlt     = {ecur_d[AW-1], ecur_d} - {eprev_q[AW-1], eprev_q};
    dlt_abs = dlt[AW] ? (AW+1)'(-dlt) : (AW+1)'(dlt);
    iter_done = dlt_abs < Tol;
    iter_last = iter_q == IW'(MAX_ITERATIONS - 1);
    dval    = c30_q - $signed({2'b00, ecc_q, 14'd0});
    d_mag   = dval[31] ? 32'(-dval) : 32'(dval);
    sq_sum  = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
    sq_ge   = {1'b0, sq_v_q} >= sq_sum;
    out_free = !out_valid_q || !out_stall_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = (period_q == 32'd0) ? ST_MMUL : ST_DIV;
      ST_DIV:  if (cnt_q == 6'd63) state_d = ST_MMUL;
      ST_MMUL: state_d = ST_MSET;
      ST_MSET: state_d = ST_RED0;
      ST_RED0: state_d = ST_RED;
      ST_RED:  if (y_q < PiHalfQ30) state_d = ST_SQ;
      ST_SQ:   state_d = ST_X2;
      ST_X2:   state_d = ST_TM;
      ST_TM:   state_d = ST_TR;
      ST_TR:   state_d = ST_TQ;
      ST_TQ:   state_d = ST_TC;
      ST_TC:   state_d = (cos_sel_q && k_q == 3'd7) ? ST_TFIN : ST_TM;
      ST_TFIN: state_d = final_q ? ST_XMUL : ST_IMUL;
      ST_IMUL: state_d = ST_IUPD;
      ST_IUPD: state_d = ST_RED0;
      ST_XMUL: state_d = ST_XRND;
      ST_XRND: state_d = ST_SQI;
      ST_SQI:  state_d = ST_SQRT;
      ST_SQRT: if (cnt_q == 6'd30) state_d = ST_YM1;
      ST_YM1:  state_d = ST_YM2;
      ST_YM2:  state_d = ST_YRND;
      ST_YRND: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    in_stall_o = state_q != ST_IDLE;
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_q)
      ST_MMUL: begin mul_a = dq_q[31:0]; mul_b = TwoPiFrac; end
      ST_SQ:   begin mul_a = {2'b00, ra_q}; mul_b = {2'b00, ra_q}; end
      ST_TM:   begin
        mul_a = cos_sel_q ? {1'b0, tc_q} : {1'b0, ts_q};
        mul_b = {2'b00, x2_q};
      end
      ST_TR:   begin mul_a = {2'b00, n_val}; mul_b = term_recip(k_q, cos_sel_q); end
      ST_TQ:   begin mul_a = {2'b00, qe_val}; mul_b = {24'd0, t_div}; end
      ST_IMUL: begin mul_a = {16'd0, ecc_q}; mul_b = s_abs; end
      ST_XMUL: begin mul_a = {8'd0, semi_q}; mul_b = d_mag; end
      ST_XRND: begin mul_a = {16'd0, ecc_q}; mul_b = {16'd0, ecc_q}; end
      ST_YM1:  begin mul_a = s_abs; mul_b = {1'b0, sq_res_q[30:0]}; end
      ST_YM2:  begin mul_a = {8'd0, semi_q}; mul_b = {1'b0, 31'(prod_q >> 30)}; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
    out_valid_o = out_valid_q;
    pos_x_o     = pos_x_q;
    pos_y_o     = pos_y_q;
    converged_o = conv_out_q;
  end

  // the y product is held while the finished result waits for the output register
  always_ff @(posedge clk_i) begin
    if (state_q != ST_YRND) prod_q <= mul_a * mul_b;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      semi_q      <= 24'd1;
      ecc_q       <= 16'd0;
      period_q    <= 32'd1;
      out_valid_q <= 1'b0;
      cnt_q       <= 6'd0;
      iter_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSemiMajor:    semi_q   <= cfg_data_i[23:0];
          CfgEccentricity: ecc_q    <= cfg_data_i[15:0];
          CfgPeriod:       period_q <= cfg_data_i;
          default:         ;
        endcase
      end
      if (state_q == ST_YRND && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin cnt_q <= 6'd0; iter_q <= '0; end
        ST_DIV:  cnt_q <= cnt_q + 6'd1;
        ST_SQI:  cnt_q <= 6'd0;
        ST_SQRT: cnt_q <= cnt_q + 6'd1;
        ST_IUPD: iter_q <= iter_q + IW'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        // long division of time * 2^32 by the period; low quotient bits are the phase
        dq_q    <= (period_q == 32'd0) ? 64'd0 : {time_req_i, 32'd0};
        rem_q   <= 32'd0;
        conv_q  <= 1'b0;
        final_q <= 1'b0;
      end
      ST_DIV: begin
        rem_q <= div_ge ? 32'(r_sh - {1'b0, period_q}) : r_sh[31:0];
        dq_q  <= {dq_q[62:0], div_ge};
      end
      ST_MSET: begin
        m_q     <= $signed(AW'(m30 >> QShift));
        eprev_q <= $signed(AW'(m30 >> QShift));
        ang_q   <= $signed(AW'(m30 >> QShift));
      end
      ST_RED0: begin
        y_q    <= (34'(ang_mag) << QShift) + PiQuarterQ30;
        quad_q <= 3'd0;
      end
      ST_RED: begin
        if (y_q >= PiHalfQ30) begin
          y_q    <= y_q - PiHalfQ30;
          quad_q <= quad_q + 3'd1;
        end else begin
          rneg_q <= r_diff[34];
          ra_q   <= r_diff[34] ? 30'(-r_diff) : r_diff[29:0];
        end
      end
      ST_X2: begin
        x2_q      <= 30'(prod_q >> 30);
        ts_q      <= {1'b0, ra_q};
        tc_q      <= 31'(OneQ30);
        ss_q      <= $signed({2'b00, ra_q});
        cc_q      <= OneQ30;
        k_q       <= 3'd1;
        cos_sel_q <= 1'b0;
      end
      ST_TR: n_q <= n_val;
      ST_TQ: qe_q <= qe_val;
      ST_TC: begin
        // odd terms subtract, even terms add
        if (cos_sel_q) begin
          tc_q <= {1'b0, term};
          cc_q <= k_q[0] ? cc_q - $signed({2'b00, term}) : cc_q + $signed({2'b00, term});
          k_q  <= k_q + 3'd1;
        end else begin
          ts_q <= {1'b0, term};
          ss_q <= k_q[0] ? ss_q - $signed({2'b00, term}) : ss_q + $signed({2'b00, term});
        end
        cos_sel_q <= !cos_sel_q;
      end
      ST_TFIN: begin
        s30_q <= ang_q[AW-1] ? -sn : sn;
        c30_q <= cn;
      end
      ST_IUPD: begin
        ang_q  <= ecur_d;
        eprev_q <= ecur_d;
        if (iter_done) conv_q <= 1'b1;
        if (iter_done || iter_last) final_q <= 1'b1;
      end
      ST_XMUL: dneg_q <= dval[31];
      ST_XRND: xres_q <= round_sat(dneg_q, prod_q);
      ST_SQI: begin
        sq_v_q   <= {(33'h100000000 - {1'b0, prod_q[31:0]}), 28'd0};
        sq_res_q <= 61'd0;
        sq_bit_q <= 61'd1 << 60;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sq_v_q   <= 61'({1'b0, sq_v_q} - sq_sum);
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      ST_YRND: begin
        if (out_free) begin
          pos_x_q    <= xres_q;
          pos_y_q    <= round_sat(s30_q[31], prod_q);
          conv_out_q <= conv_q;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // a new result only comes from the final rounding step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_YRND))
    else $error("result raised outside final step");

  // update count stays within the limit
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= IW'(MAX_ITERATIONS))
    else $error("iteration count beyond limit");

  // partial remainder of the period divider stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < period_q)
    else $error("divider remainder out of range");

  // range reduction needs only a few quarter turns
  a_quad_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RED |-> quad_q <= 3'd6)
    else $error("range reduction runaway");
`endif

endmodule
`default_nettype wire
